[rtl/core/jc_pkg.sv]
// Shared types, codes and fixed-point helpers for the Jacobian column pipeline.
`default_nettype none
package jc_pkg;

  typedef enum logic [1:0] {
    KIND_REVOLUTE   = 2'd0,
    KIND_CONTINUOUS = 2'd1,
    KIND_PRISMATIC  = 2'd2,
    KIND_OTHER      = 2'd3
  } kind_t;

  // Load strobes for the four pipeline stages
  typedef struct packed {
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;
  } pipe_ctrl_t;

  // World axis word handed from the rotate stages to the linear stages
  typedef struct packed {
    logic        active;
    kind_t       kind;
    logic [5:0]  col;
    logic        sat;
    logic [47:0] w;
    logic [50:0] r;
  } axis_word_t;

  // Pick signed 16-bit component k out of a packed vector
  function automatic logic signed [15:0] comp(input logic [47:0] v, input logic [1:0] k);
    return v[16*k +: 16];
  endfunction

  // Round half up, drop 14 fraction bits, clip to 16 bits; bit 16 flags a clip
  function automatic logic [16:0] round_sat14(input logic signed [33:0] x);
    logic signed [33:0] y;
    logic signed [19:0] q;
    y = x + 34'sd8192;
    q = 20'(y >>> 14);
    if (q > 20'sd32767) begin
      return {1'b1, 16'h7fff};
    end else if (q < -20'sd32768) begin
      return {1'b1, 16'h8000};
    end
    return {1'b0, q[15:0]};
  endfunction

endpackage
`default_nettype wire

[rtl/core/jc_pipe_ctrl.sv]
// Valid bits and stall chain of the four-stage column pipeline.
`default_nettype none
module jc_pipe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output jc_pkg::pipe_ctrl_t   ctrl
);

  logic [3:0] vld;
  logic [3:0] ready;

  // Work out, from the output backwards, which stages may take a new word
  always_comb begin
    ready[3] = !vld[3] || !out_stall;
    for (int k = 2; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld[3];

  assign ctrl.s1_load = in_valid && ready[0];
  assign ctrl.s2_load = vld[0] && ready[1];
  assign ctrl.s3_load = vld[1] && ready[2];
  assign ctrl.s4_load = vld[2] && ready[3];

  // Advance valid bits wherever a stage is free to move
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) vld[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (ready[k]) vld[k] <= vld[k-1];
      end
    end
  end

`ifndef SYNTHESIS
  // A stall at the input only arises with every stage full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld == 4'hf))
    else $error("input stalled with a free stage");

  // A held stage keeps its word
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && out_stall) |=> vld[3])
    else $error("stalled output word lost");

  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && !ready[1]) |=> vld[1])
    else $error("stalled middle word lost");

  // An accepted word lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted word not held in first stage");
`endif

endmodule
`default_nettype wire

[rtl/core/jc_rotate.sv]
// Stages one and two: world axis as rotation times local axis, and lever arm.
`default_nettype none
module jc_rotate #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic               clk,
  input  wire jc_pkg::pipe_ctrl_t ctrl,
  input  wire logic [1:0]         joint_kind,
  input  wire logic [5:0]         column_index,
  input  wire logic [47:0]        rot_row_x,
  input  wire logic [47:0]        rot_row_y,
  input  wire logic [47:0]        rot_row_z,
  input  wire logic [47:0]        joint_origin,
  input  wire logic [47:0]        local_axis,
  input  wire logic [47:0]        tool_point,
  output jc_pkg::axis_word_t      axis
);

  logic [47:0]        rows [3];
  logic signed [31:0] prod [3][3];
  logic signed [16:0] r1   [3];
  logic               active1;
  jc_pkg::kind_t      kind1;
  logic [5:0]         col1;

  logic [47:0]        w2;
  logic               sat2;
  logic [50:0]        r2;

  assign rows[0] = rot_row_x;
  assign rows[1] = rot_row_y;
  assign rows[2] = rot_row_z;

  // Stage one: nine axis products and the tool lever arm
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= jc_pkg::comp(rows[i], 2'(j)) * jc_pkg::comp(local_axis, 2'(j));
        end
        r1[i] <= 17'(jc_pkg::comp(tool_point, 2'(i)))
               - 17'(jc_pkg::comp(joint_origin, 2'(i)));
      end
      active1 <= (7'(column_index) < 7'(MAX_JOINTS))
              && (jc_pkg::kind_t'(joint_kind) != jc_pkg::KIND_OTHER);
      kind1   <= jc_pkg::kind_t'(joint_kind);
      col1    <= column_index;
    end
  end

  // Sum each row, round to Q1.14 and clip
  always_comb begin
    logic signed [33:0] acc;
    logic [16:0]        res;
    sat2 = 1'b0;
    w2   = '0;
    r2   = '0;
    for (int i = 0; i < 3; i++) begin
      acc = 34'(prod[i][0]) + 34'(prod[i][1]) + 34'(prod[i][2]);
      res = jc_pkg::round_sat14(acc);
      w2[16*i +: 16] = res[15:0];
      sat2 = sat2 | res[16];
      r2[17*i +: 17] = r1[i];
    end
  end

  // Stage two register
  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      axis.active <= active1;
      axis.kind   <= kind1;
      axis.col    <= col1;
      axis.sat    <= sat2;
      axis.w      <= w2;
      axis.r      <= r2;
    end
  end

endmodule
`default_nettype wire

[rtl/core/jc_linear.sv]
// Stages three and four: cross product or prismatic scaling, and result word.
`default_nettype none
module jc_linear (
  input  wire logic               clk,
  input  wire jc_pkg::pipe_ctrl_t ctrl,
  input  wire jc_pkg::axis_word_t axis,
  output logic [5:0]              column_out,
  output logic [47:0]             linear_part,
  output logic [47:0]             angular_part,
  output logic                    saturated
);

  logic signed [15:0] w  [3];
  logic signed [16:0] r  [3];
  logic signed [32:0] m  [6];
  logic [47:0]        prism_next;
  logic [47:0]        prism3;
  logic [47:0]        w3;
  logic               active3;
  jc_pkg::kind_t      kind3;
  logic [5:0]         col3;
  logic               sat3;

  logic [47:0]        cross4;
  logic               csat4;

  // Unpack axis and lever arm; rescale the axis from Q1.14 to Q7.8 for a prismatic joint
  always_comb begin
    logic signed [16:0] p;
    prism_next = '0;
    for (int i = 0; i < 3; i++) begin
      w[i] = axis.w[16*i +: 16];
      r[i] = axis.r[17*i +: 17];
      p = (17'(w[i]) + 17'sd32) >>> 6;
      prism_next[16*i +: 16] = p[15:0];
    end
  end

  // Stage three: six cross products and the prismatic rescale
  always_ff @(posedge clk) begin
    if (ctrl.s3_load) begin
      m[0] <= w[1] * r[2];
      m[1] <= w[2] * r[1];
      m[2] <= w[2] * r[0];
      m[3] <= w[0] * r[2];
      m[4] <= w[0] * r[1];
      m[5] <= w[1] * r[0];
      prism3  <= prism_next;
      w3      <= axis.w;
      active3 <= axis.active;
      kind3   <= axis.kind;
      col3    <= axis.col;
      sat3    <= axis.sat;
    end
  end

  // Subtract product pairs, round to Q7.8 and clip
  always_comb begin
    logic signed [33:0] d;
    logic [16:0]        res;
    csat4  = 1'b0;
    cross4 = '0;
    for (int i = 0; i < 3; i++) begin
      d = 34'(m[2*i]) - 34'(m[2*i+1]);
      res = jc_pkg::round_sat14(d);
      cross4[16*i +: 16] = res[15:0];
      csat4 = csat4 | res[16];
    end
  end

  // Stage four: select the column by joint kind, or zeros for an inactive joint
  always_ff @(posedge clk) begin
    if (ctrl.s4_load) begin
      column_out <= col3;
      if (!active3) begin
        linear_part  <= '0;
        angular_part <= '0;
        saturated    <= 1'b0;
      end else if (kind3 == jc_pkg::KIND_PRISMATIC) begin
        linear_part  <= prism3;
        angular_part <= '0;
        saturated    <= sat3;
      end else begin
        linear_part  <= cross4;
        angular_part <= w3;
        saturated    <= sat3 | csat4;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/jacobian_column.sv]
// Order: an accepted input word moves through four registered stages (axis
//   products, row sums, cross products, result select), each holding one word.
// Throughput: one word per cycle while out_stall is low; out_valid is vld[3].
// Reset: synchronous rst clears the stage valid bits; data registers keep
//   their contents and are not cleared.
`default_nettype none
module jacobian_column #(
  parameter int MAX_JOINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  joint_kind,
  input  wire logic [5:0]  column_index,
  input  wire logic [47:0] rot_row_x,
  input  wire logic [47:0] rot_row_y,
  input  wire logic [47:0] rot_row_z,
  input  wire logic [47:0] joint_origin,
  input  wire logic [47:0] local_axis,
  input  wire logic [47:0] tool_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       column_out,
  output logic [47:0]      linear_part,
  output logic [47:0]      angular_part,
  output logic             saturated
);

  jc_pkg::pipe_ctrl_t ctrl;
  jc_pkg::axis_word_t axis;

  jc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  jc_rotate #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_rotate (
    .clk          (clk),
    .ctrl         (ctrl),
    .joint_kind   (joint_kind),
    .column_index (column_index),
    .rot_row_x    (rot_row_x),
    .rot_row_y    (rot_row_y),
    .rot_row_z    (rot_row_z),
    .joint_origin (joint_origin),
    .local_axis   (local_axis),
    .tool_point   (tool_point),
    .axis         (axis)
  );

  jc_linear u_linear (
    .clk          (clk),
    .ctrl         (ctrl),
    .axis         (axis),
    .column_out   (column_out),
    .linear_part  (linear_part),
    .angular_part (angular_part),
    .saturated    (saturated)
  );

endmodule
`default_nettype wire

[tb/sv/tb_jacobian_column.sv]
// Self-checking testbench for the Jacobian column pipeline, with a predictor and backpressure.
`timescale 1ns / 100ps

module tb_jacobian_column;

  localparam int JOINT_LIMIT = 64;
  localparam int HOLD_CYCLES = 60;
  localparam int Q14_ONE     = 16384;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY
  } stall_mode_t;

  typedef struct {
    jc_pkg::kind_t kind;
    logic [5:0]    col;
    logic [47:0]   rot_x;
    logic [47:0]   rot_y;
    logic [47:0]   rot_z;
    logic [47:0]   origin;
    logic [47:0]   axis;
    logic [47:0]   tool;
  } joint_t;

  typedef struct {
    logic [5:0]  col;
    logic [47:0] lin;
    logic [47:0] ang;
    logic        sat;
  } column_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  joint_kind = '0;
  logic [5:0]  column_index = '0;
  logic [47:0] rot_row_x = '0;
  logic [47:0] rot_row_y = '0;
  logic [47:0] rot_row_z = '0;
  logic [47:0] joint_origin = '0;
  logic [47:0] local_axis = '0;
  logic [47:0] tool_point = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  column_out;
  logic [47:0] linear_part;
  logic [47:0] angular_part;
  logic        saturated;

  column_t     pending_columns[$];
  int          mismatch_count = 0;
  int          gap_max = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_count = 0;
  int          run_left = 0;
  logic        stall_run = 1'b0;

  jacobian_column #(.MAX_JOINTS(JOINT_LIMIT)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .joint_kind   (joint_kind),
    .column_index (column_index),
    .rot_row_x    (rot_row_x),
    .rot_row_y    (rot_row_y),
    .rot_row_z    (rot_row_z),
    .joint_origin (joint_origin),
    .local_axis   (local_axis),
    .tool_point   (tool_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .column_out   (column_out),
    .linear_part  (linear_part),
    .angular_part (angular_part),
    .saturated    (saturated)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint comp16(input logic [47:0] v, input int k);
    logic signed [15:0] c;
    c = v[16*k +: 16];
    return longint'(c);
  endfunction

  function automatic logic [47:0] pack3(input longint x, input longint y, input longint z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  // Add half an LSB, then floor
  function automatic longint round_half(input longint x, input int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic bit over16(input longint x);
    return (x > 32767) || (x < -32768);
  endfunction

  function automatic longint sat16(input longint x);
    if (x > 32767) begin
      return 32767;
    end
    if (x < -32768) begin
      return -32768;
    end
    return x;
  endfunction

  function automatic column_t predict_column(input joint_t j);
    column_t     res;
    logic [47:0] rows [3];
    longint      w [3];
    longint      lin [3];
    longint      ang [3];
    longint      r [3];
    longint      xprod [3];
    longint      acc;
    longint      v;
    bit          clip;
    clip = 1'b0;
    rows[0] = j.rot_x;
    rows[1] = j.rot_y;
    rows[2] = j.rot_z;
    for (int i = 0; i < 3; i++) begin
      w[i] = 0;
      lin[i] = 0;
      ang[i] = 0;
    end
    if (int'(j.col) < JOINT_LIMIT && j.kind != jc_pkg::KIND_OTHER) begin
      // World axis: rotation times local axis, back to Q1.14
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          acc += comp16(rows[i], k) * comp16(j.axis, k);
        end
        v = round_half(acc, 14);
        clip |= over16(v);
        w[i] = sat16(v);
      end
      if (j.kind == jc_pkg::KIND_PRISMATIC) begin
        for (int i = 0; i < 3; i++) begin
          v = round_half(w[i], 6);
          clip |= over16(v);
          lin[i] = sat16(v);
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          r[i] = comp16(j.tool, i) - comp16(j.origin, i);
          ang[i] = w[i];
        end
        xprod[0] = w[1] * r[2] - w[2] * r[1];
        xprod[1] = w[2] * r[0] - w[0] * r[2];
        xprod[2] = w[0] * r[1] - w[1] * r[0];
        for (int i = 0; i < 3; i++) begin
          v = round_half(xprod[i], 14);
          clip |= over16(v);
          lin[i] = sat16(v);
        end
      end
    end
    res.col = j.col;
    res.lin = pack3(lin[0], lin[1], lin[2]);
    res.ang = pack3(ang[0], ang[1], ang[2]);
    res.sat = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic joint_t make_joint(input jc_pkg::kind_t kind, input int col,
                                        input logic [47:0] rx, input logic [47:0] ry,
                                        input logic [47:0] rz, input logic [47:0] org,
                                        input logic [47:0] ax, input logic [47:0] tl);
    joint_t j;
    j.kind = kind;
    j.col = 6'(col);
    j.rot_x = rx;
    j.rot_y = ry;
    j.rot_z = rz;
    j.origin = org;
    j.axis = ax;
    j.tool = tl;
    return j;
  endfunction

  // Mostly plausible magnitudes, some raw bits, a few extremes
  function automatic logic [15:0] rand_comp(input bit is_pos);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      if (is_pos) begin
        return 16'(int'($urandom_range(0, 4096)) - 2048);
      end
      return 16'(int'($urandom_range(0, 32768)) - 16384);
    end
    if (sel < 9) begin
      return 16'($urandom);
    end
    case ($urandom_range(0, 3))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic logic [47:0] rand_vec(input bit is_pos);
    return {rand_comp(is_pos), rand_comp(is_pos), rand_comp(is_pos)};
  endfunction

  function automatic joint_t rand_joint();
    return make_joint(jc_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                      rand_vec(1'b0), rand_vec(1'b0), rand_vec(1'b0),
                      rand_vec(1'b1), rand_vec(1'b0), rand_vec(1'b1));
  endfunction

  // After an optional idle gap, offer one word, hold it until taken, then record its expected column
  task automatic send_joint(input joint_t j);
    int  gap;
    bit  took;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    joint_kind   <= j.kind;
    column_index <= j.col;
    rot_row_x    <= j.rot_x;
    rot_row_y    <= j.rot_y;
    rot_row_z    <= j.rot_z;
    joint_origin <= j.origin;
    local_axis   <= j.axis;
    tool_point   <= j.tool;
    in_valid     <= 1'b1;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    pending_columns.push_back(predict_column(j));
  endtask

  task automatic send_random_run(input int count);
    for (int n = 0; n < count; n++) begin
      send_joint(rand_joint());
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // Stall the output: a long hold on request, otherwise the current pattern
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_count <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall  <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 99) < 35);
        end
        default: begin
          if (run_left == 0) begin
            stall_run <= !stall_run;
            run_left  <= $urandom_range(1, 8);
            out_stall <= !stall_run;
          end else begin
            run_left  <= run_left - 1;
            out_stall <= stall_run;
          end
        end
      endcase
    end
  end

  // Compare each word taken at the coming edge with the oldest expectation
  always @(negedge clk) begin : check_output
    column_t exp_col;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_columns.size() == 0) begin
        $error("output word with no column pending: column_out %0d", column_out);
        mismatch_count++;
      end else begin
        exp_col = pending_columns.pop_front();
        if (column_out !== exp_col.col) begin
          $error("column_out: expected %0d, got %0d", exp_col.col, column_out);
          mismatch_count++;
        end
        if (linear_part !== exp_col.lin) begin
          $error("linear_part: expected %h, got %h", exp_col.lin, linear_part);
          mismatch_count++;
        end
        if (angular_part !== exp_col.ang) begin
          $error("angular_part: expected %h, got %h", exp_col.ang, angular_part);
          mismatch_count++;
        end
        if (saturated !== exp_col.sat) begin
          $error("saturated: expected %b, got %b", exp_col.sat, saturated);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Every joint kind on an identity pose, plus the zero column of an unknown kind and a rotated pose
  task automatic test_joint_kinds();
    logic [47:0] ix, iy, iz, ax_z, tl;
    ix   = pack3(Q14_ONE, 0, 0);
    iy   = pack3(0, Q14_ONE, 0);
    iz   = pack3(0, 0, Q14_ONE);
    ax_z = pack3(0, 0, Q14_ONE);
    tl   = pack3(256, 0, 0);
    stall_mode <= STALL_RANDOM;
    gap_max = 3;
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 0, ix, iy, iz, '0, ax_z, tl));
    send_joint(make_joint(jc_pkg::KIND_CONTINUOUS, 1, ix, iy, iz, '0, ax_z, tl));
    send_joint(make_joint(jc_pkg::KIND_PRISMATIC, 2, ix, iy, iz, '0, ax_z, tl));
    send_joint(make_joint(jc_pkg::KIND_OTHER, 3, ix, iy, iz, pack3(7, -9, 11), ax_z, tl));
    // Rotated pose with an offset origin
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 4, iy, pack3(-Q14_ONE, 0, 0), iz,
                          pack3(128, -64, 32), pack3(Q14_ONE, 0, 0), pack3(-300, 500, 77)));
  endtask

  // Field extremes, clipping in both stages and both directions, rounding ties
  task automatic test_extremes();
    logic [47:0] ix, iy, iz, all_max, all_min;
    ix      = pack3(Q14_ONE, 0, 0);
    iy      = pack3(0, Q14_ONE, 0);
    iz      = pack3(0, 0, Q14_ONE);
    all_max = pack3(32767, 32767, 32767);
    all_min = pack3(-32768, -32768, -32768);
    stall_mode <= STALL_BURSTY;
    gap_max = 2;
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 0, '0, '0, '0, '0, '0, '0));
    for (int k = 0; k < 4; k++) begin
      send_joint(make_joint(jc_pkg::kind_t'(k), 63, '1, '1, '1, '1, '1, '1));
    end
    // World axis clipped high, then low
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 10, all_max, all_max, all_max, '0,
                          all_max, all_max));
    send_joint(make_joint(jc_pkg::KIND_PRISMATIC, 11, all_min, all_min, all_min, '0,
                          all_max, '0));
    send_joint(make_joint(jc_pkg::KIND_CONTINUOUS, 12, all_min, all_max, all_min,
                          all_max, all_min, all_min));
    // Cross product clipped high, then low
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 13, ix, iy, iz, pack3(0, -32768, 0),
                          pack3(Q14_ONE, 0, 0), pack3(0, 32767, 0)));
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 14, ix, iy, iz, pack3(0, 32767, 0),
                          pack3(Q14_ONE, 0, 0), pack3(0, -32768, 0)));
    // Half-LSB ties in the prismatic conversion and in the cross product
    send_joint(make_joint(jc_pkg::KIND_PRISMATIC, 15, ix, iy, iz, '0, pack3(-32, 32, 96),
                          '0));
    send_joint(make_joint(jc_pkg::KIND_REVOLUTE, 16, ix, iy, iz, '0, pack3(0, 0, 1),
                          pack3(8192, 8192, 0)));
    send_joint(make_joint(jc_pkg::KIND_CONTINUOUS, 17, ix, iy, iz, pack3(-8192, 0, 0),
                          pack3(0, 0, -1), pack3(0, -8192, 0)));
  endtask

  task automatic test_random_idle();
    stall_mode <= STALL_RANDOM;
    gap_max = 8;
    send_random_run(150);
  endtask

  task automatic test_random_bursty();
    stall_mode <= STALL_BURSTY;
    gap_max = 0;
    burst_left = 0;
    send_random_run(100);
    gap_max = 10;
    send_random_run(100);
  endtask

  task automatic test_streaming();
    stall_mode <= STALL_NONE;
    gap_max = 0;
    send_random_run(50);
  endtask

  // Hold the output for a long stretch while words keep coming, so the input stalls
  task automatic test_backpressure();
    stall_mode <= STALL_NONE;
    gap_max = 0;
    hold_token <= hold_token + 1;
    send_random_run(30);
    stall_mode <= STALL_RANDOM;
    send_random_run(10);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_joint_kinds();
    test_extremes();
    test_random_idle();
    test_backpressure();
    test_random_bursty();
    test_streaming();

    // Drain, then watch for stray words
    in_valid <= 1'b0;
    while (pending_columns.size() != 0) begin
      @(posedge clk);
    end
    stall_mode <= STALL_NONE;
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[jacobian_column.f]
rtl/core/jc_pkg.sv
rtl/core/jc_pipe_ctrl.sv
rtl/core/jc_rotate.sv
rtl/core/jc_linear.sv
rtl/core/jacobian_column.sv
tb/sv/tb_jacobian_column.sv
